// File: rtl/core/assert_macros.svh
// Assertion macros used by the port checker.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define E2Q_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define E2Q_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/e2q_pkg.sv
// Shared types, constants and arithmetic helpers for euler_to_quaternion.
// Depends on nothing.
`default_nettype none
package e2q_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int PART_WIDTH_DEFAULT   = 16;
   localparam int ATAN_ENTRIES         = 24;
   localparam int ANGLE_WIDTH          = 16;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
   localparam logic signed [65:0] ROUND_Q30   = 66'sd536870912;

   typedef logic signed [32:0] q30_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
      logic    flip;
   } axis_type;

   typedef struct packed {
      axis_type ax;
      axis_type ay;
      axis_type az;
   } triple_type;

   typedef struct packed {
      q30_type w;
      q30_type x;
      q30_type y;
      q30_type z;
   } quat_type;

   function automatic q30_type atan_q30(input int idx);
      q30_type r;
      case (idx)
         0:       r = 33'sh03243F6A8;
         1:       r = 33'sh01DAC6705;
         2:       r = 33'sh00FADBAFC;
         3:       r = 33'sh007F56EA6;
         4:       r = 33'sh003FEAB76;
         5:       r = 33'sh001FFD55B;
         6:       r = 33'sh000FFFAAA;
         7:       r = 33'sh0007FFF55;
         8:       r = 33'sh0003FFFEA;
         9:       r = 33'sh0001FFFFD;
         10:      r = 33'sh0000FFFFF;
         11:      r = 33'sh00007FFFF;
         12:      r = 33'sh00003FFFF;
         13:      r = 33'sh00001FFFF;
         14:      r = 33'sh00000FFFF;
         15:      r = 33'sh000007FFF;
         16:      r = 33'sh000003FFF;
         17:      r = 33'sh000001FFF;
         18:      r = 33'sh000000FFF;
         19:      r = 33'sh0000007FF;
         20:      r = 33'sh0000003FF;
         21:      r = 33'sh0000001FF;
         22:      r = 33'sh0000000FF;
         23:      r = 33'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 times Q30, rounded half up back to Q30.
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [65:0] p;
      p = a * b;
      p = p + ROUND_Q30;
      return q30_type'(p >>> 30);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/euler_to_quaternion.sv
// Euler angles (x-y-z order) to unit quaternion, fixed point.
// Top level; depends on e2q_pkg, e2q_cordic_cell and e2q_product.
//
// Usage:
//   Input channel req_*: three signed angles, 4096 units per radian. One beat
//   is taken when req_valid and req_ready are both high.
//   Result channel rsp_*: w, x, y, z in Q1.(PART_WIDTH-2), rounded and
//   saturated. One result beat for every input beat, in order.
//   Path: the fold register loads at the accepting edge; then the beat
//   passes one CORDIC cell per step, where STEPS is CORDIC_STEPS capped at
//   24, and then three product stages before rsp_valid.
//   Throughput: one beat per cycle; every stage is a register with its own
//   valid bit, so a new beat enters each cycle while the row keeps moving.
//   Stall: when rsp_ready is low the result holds; stages behind it keep
//   filling bubbles, and req_ready drops only once every stage is full.
//   Reset: synchronous, active high; clears all valid bits, the block is
//   empty and ready in the cycle after reset drops.
`default_nettype none
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT,
   parameter int PART_WIDTH   = PART_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_x,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_y,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_z,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic signed [PART_WIDTH-1:0]  rsp_w_part,
   output      logic signed [PART_WIDTH-1:0]  rsp_x_part,
   output      logic signed [PART_WIDTH-1:0]  rsp_y_part,
   output      logic signed [PART_WIDTH-1:0]  rsp_z_part
);

   // the rotation table stops at its last entry
   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   // fold stage: half angle in Q30, folded into +-pi/2
   function automatic axis_type fold(input logic signed [ANGLE_WIDTH-1:0] raw);
      axis_type           a;
      logic signed [33:0] z;
      z      = 34'(raw) <<< 17;
      a.x    = GAIN_Q30;
      a.y    = '0;
      a.flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z      = z - PI_Q30;
         a.flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z      = z + PI_Q30;
         a.flip = 1'b1;
      end
      a.z = z[32:0];
      return a;
   endfunction

   logic       fold_valid_ff, fold_valid_in;
   triple_type fold_ff;

   logic       row_valid [STEPS+1];
   logic       row_ready [STEPS+1];
   triple_type row_data  [STEPS+1];

   assign req_ready     = !fold_valid_ff || row_ready[0];
   assign fold_valid_in = req_ready ? req_valid : fold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= fold_valid_in;
      end
   end

   // capture and fold on each accepted beat
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         fold_ff.ax <= fold(req_angle_x);
         fold_ff.ay <= fold(req_angle_y);
         fold_ff.az <= fold(req_angle_z);
      end
   end

   assign row_valid[0] = fold_valid_ff;
   assign row_data[0]  = fold_ff;

   // row of rotation cells, one per CORDIC step
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      e2q_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (row_valid[i]),
         .in_ready  (row_ready[i]),
         .in_data   (row_data[i]),
         .out_valid (row_valid[i+1]),
         .out_ready (row_ready[i+1]),
         .out_data  (row_data[i+1])
      );
   end

   e2q_product #(
      .PART_WIDTH (PART_WIDTH)
   ) u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid[STEPS]),
      .in_ready  (row_ready[STEPS]),
      .in_data   (row_data[STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .w_part    (rsp_w_part),
      .x_part    (rsp_x_part),
      .y_part    (rsp_y_part),
      .z_part    (rsp_z_part)
   );

endmodule
`default_nettype wire

// File: rtl/core/e2q_cordic_cell.sv
// One CORDIC rotation cell for all three axes, with its own beat register.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cordic_cell
   import e2q_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output      logic       in_ready,
   input  wire triple_type in_data,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      triple_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   triple_type data_ff;
   triple_type data_in;

   function automatic axis_type rotate(input axis_type a);
      axis_type r;
      r = a;
      if (a.z >= 0) begin
         r.x = a.x - (a.y >>> STEP);
         r.y = a.y + (a.x >>> STEP);
         r.z = a.z - atan_q30(STEP);
      end else begin
         r.x = a.x + (a.y >>> STEP);
         r.y = a.y - (a.x >>> STEP);
         r.z = a.z + atan_q30(STEP);
      end
      return r;
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in   = in_ready ? in_valid : valid_ff;
      data_in    = data_ff;
      if (in_ready && in_valid) begin
         data_in.ax = rotate(in_data.ax);
         data_in.ay = rotate(in_data.ay);
         data_in.az = rotate(in_data.az);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// File: rtl/core/e2q_product.sv
// Hamilton product (qx*qy)*qz and output rounding, three beat stages.
// Depends on e2q_pkg.
`default_nettype none
module e2q_product
   import e2q_pkg::*;
#(
   parameter int PART_WIDTH = PART_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output      logic                         in_ready,
   input  wire triple_type                   in_data,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      logic signed [PART_WIDTH-1:0] w_part,
   output      logic signed [PART_WIDTH-1:0] x_part,
   output      logic signed [PART_WIDTH-1:0] y_part,
   output      logic signed [PART_WIDTH-1:0] z_part
);

   localparam int SHIFT = 32 - PART_WIDTH;
   localparam logic signed [34:0] RND    = (SHIFT > 0) ? 35'(64'sd1 <<< (SHIFT - 1)) : '0;
   localparam logic signed [34:0] SAT_HI = 35'((64'sd1 <<< (PART_WIDTH - 1)) - 64'sd1);
   localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

   function automatic logic signed [PART_WIDTH-1:0] to_part(input logic signed [33:0] v);
      logic signed [34:0] r;
      r = (35'(v) + RND) >>> SHIFT;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[PART_WIDTH-1:0];
   endfunction

   // stage A: qx*qy, four products
   logic     va_ff, va_in, rdy_a;
   quat_type ta_ff;
   q30_type  cz_a_ff, sz_a_ff;
   // stage B: eight rounded products against qz
   logic     vb_ff, vb_in, rdy_b;
   q30_type  wc_ff, zs_ff, xc_ff, ys_ff, yc_ff, xs_ff, ws_ff, zc_ff;
   // stage C: sums, rounding, saturation
   logic     vc_ff, vc_in, rdy_c;
   logic signed [PART_WIDTH-1:0] w_ff, x_ff, y_ff, z_ff;

   q30_type cx, sx, cy, sy, cz, sz;

   always_comb begin
      cx = in_data.ax.flip ? -in_data.ax.x : in_data.ax.x;
      sx = in_data.ax.flip ? -in_data.ax.y : in_data.ax.y;
      cy = in_data.ay.flip ? -in_data.ay.x : in_data.ay.x;
      sy = in_data.ay.flip ? -in_data.ay.y : in_data.ay.y;
      cz = in_data.az.flip ? -in_data.az.x : in_data.az.x;
      sz = in_data.az.flip ? -in_data.az.y : in_data.az.y;
   end

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   assign va_in = rdy_a ? in_valid : va_ff;
   assign vb_in = rdy_b ? va_ff    : vb_ff;
   assign vc_in = rdy_c ? vb_ff    : vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         ta_ff.w <= mul_q30(cx, cy);
         ta_ff.x <= mul_q30(sx, cy);
         ta_ff.y <= mul_q30(cx, sy);
         ta_ff.z <= mul_q30(sx, sy);
         cz_a_ff <= cz;
         sz_a_ff <= sz;
      end
      if (rdy_b && va_ff) begin
         wc_ff <= mul_q30(ta_ff.w, cz_a_ff);
         zs_ff <= mul_q30(ta_ff.z, sz_a_ff);
         xc_ff <= mul_q30(ta_ff.x, cz_a_ff);
         ys_ff <= mul_q30(ta_ff.y, sz_a_ff);
         yc_ff <= mul_q30(ta_ff.y, cz_a_ff);
         xs_ff <= mul_q30(ta_ff.x, sz_a_ff);
         ws_ff <= mul_q30(ta_ff.w, sz_a_ff);
         zc_ff <= mul_q30(ta_ff.z, cz_a_ff);
      end
      if (rdy_c && vb_ff) begin
         w_ff <= to_part(34'(wc_ff) - 34'(zs_ff));
         x_ff <= to_part(34'(xc_ff) + 34'(ys_ff));
         y_ff <= to_part(34'(yc_ff) - 34'(xs_ff));
         z_ff <= to_part(34'(ws_ff) + 34'(zc_ff));
      end
   end

   assign out_valid = vc_ff;
   assign w_part    = w_ff;
   assign x_part    = x_ff;
   assign y_part    = y_ff;
   assign z_part    = z_ff;

endmodule
`default_nettype wire

// File: rtl/core/e2q_checker.sv
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends on e2q_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module e2q_port_checks
   import e2q_pkg::*;
#(
   parameter int PART_WIDTH = PART_WIDTH_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic signed [ANGLE_WIDTH-1:0] req_angle_x,
   input wire logic signed [ANGLE_WIDTH-1:0] req_angle_y,
   input wire logic signed [ANGLE_WIDTH-1:0] req_angle_z,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [PART_WIDTH-1:0]  rsp_w_part,
   input wire logic signed [PART_WIDTH-1:0]  rsp_x_part,
   input wire logic signed [PART_WIDTH-1:0]  rsp_y_part,
   input wire logic signed [PART_WIDTH-1:0]  rsp_z_part
);

   logic                    req_beat;
   logic                    rsp_wait;
   logic [4*PART_WIDTH-1:0] rsp_parts;

   assign req_beat = req_valid && req_ready && (req_angle_x == req_angle_x)
                     && (req_angle_y == req_angle_y) && (req_angle_z == req_angle_z);
   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign rsp_parts = {rsp_w_part, rsp_x_part, rsp_y_part, rsp_z_part};

   `E2Q_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid, "rsp beat dropped")
   `E2Q_ASSERT(a_rsp_stable, clock, reset, rsp_wait |=> $stable(rsp_parts), "rsp payload moved")
   `E2Q_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result after reset")
   `E2Q_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready && !(req_beat && rsp_valid), "not ready after reset")

endmodule

bind euler_to_quaternion e2q_port_checks #(.PART_WIDTH(PART_WIDTH)) u_e2q_checker (.*);
`default_nettype wire

// File: test/e2q_checker.sv
// Checker for euler_to_quaternion: watches both channels, predicts each
// quaternion from the accepted angles and compares results in order.
// Depends on e2q_pkg for the angle width.
`timescale 1ns / 100ps
`default_nettype none
module e2q_checker
   import e2q_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int PART_WIDTH   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_x,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_y,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_angle_z,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic signed [PART_WIDTH-1:0]  rsp_w_part,
   input  wire logic signed [PART_WIDTH-1:0]  rsp_x_part,
   input  wire logic signed [PART_WIDTH-1:0]  rsp_y_part,
   input  wire logic signed [PART_WIDTH-1:0]  rsp_z_part,
   output int                                 fail_count,
   output int                                 pending_count
);

   typedef logic signed [63:0] wide_t;
   typedef struct {
      logic signed [PART_WIDTH-1:0] w, x, y, z;
   } quat_parts_t;

   quat_parts_t quat_queue[$];

   localparam wide_t TURN_HALF = 64'sd1686629713;
   localparam wide_t TURN      = 64'sd3373259426;
   localparam wide_t K_GAIN    = 64'sd652032874;

   function automatic wide_t arctan_step(input int i);
      wide_t tab[24];
      tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
              64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
              64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
              64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
              64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
              64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return tab[i];
   endfunction

   function automatic wide_t qmul(input wide_t a, input wide_t b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   // Half-angle cosine and sine in Q30.
   task automatic half_angle_sincos(input logic signed [15:0] raw,
                                    output wide_t c, output wide_t s);
      wide_t z, x, y, nx;
      logic flip;
      int steps;
      z = wide_t'(raw) * 131072;
      x = K_GAIN;
      y = 0;
      flip = 1'b0;
      steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      if (z > TURN_HALF) begin
         z = z - TURN;
         flip = 1'b1;
      end else if (z < -TURN_HALF) begin
         z = z + TURN;
         flip = 1'b1;
      end
      for (int i = 0; i < steps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan_step(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan_step(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [PART_WIDTH-1:0] to_part(input wide_t v);
      wide_t hi, lo;
      int sh;
      sh = 32 - PART_WIDTH;
      hi = (64'sd1 <<< (PART_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[PART_WIDTH-1:0];
   endfunction

   task automatic predict_quat(input logic signed [15:0] ax, ay, az);
      wide_t cx, sx, cy, sy, cz, sz;
      wide_t tw, tx, ty, tz, qw, qx, qy, qz;
      quat_parts_t r;
      half_angle_sincos(ax, cx, sx);
      half_angle_sincos(ay, cy, sy);
      half_angle_sincos(az, cz, sz);
      // qx*qy with qx=(cx,sx,0,0), qy=(cy,0,sy,0), terms kept as in the full product
      tx = qmul(cx, 0) + qmul(sx, cy) + qmul(0, 0) - qmul(0, sy);
      ty = qmul(cx, sy) + qmul(0, cy) + qmul(0, 0) - qmul(sx, 0);
      tz = qmul(cx, 0) + qmul(0, cy) + qmul(sx, sy) - qmul(0, 0);
      tw = qmul(cx, cy) - qmul(sx, 0) - qmul(0, sy) - qmul(0, 0);
      // times qz=(cz,0,0,sz)
      qx = qmul(tw, 0) + qmul(tx, cz) + qmul(ty, sz) - qmul(tz, 0);
      qy = qmul(tw, 0) + qmul(ty, cz) + qmul(tz, 0) - qmul(tx, sz);
      qz = qmul(tw, sz) + qmul(tz, cz) + qmul(tx, 0) - qmul(ty, 0);
      qw = qmul(tw, cz) - qmul(tx, 0) - qmul(ty, 0) - qmul(tz, sz);
      r.w = to_part(qw);
      r.x = to_part(qx);
      r.y = to_part(qy);
      r.z = to_part(qz);
      quat_queue.push_back(r);
   endtask

   task automatic compare_part(input string name, input logic signed [PART_WIDTH-1:0] exp_v,
                               input logic signed [PART_WIDTH-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending_count = quat_queue.size();

   always @(posedge clock) begin
      quat_parts_t e;
      if (!reset) begin
         if (req_valid && req_ready) predict_quat(req_angle_x, req_angle_y, req_angle_z);
         if (rsp_valid && rsp_ready) begin
            if (quat_queue.size() == 0) begin
               $display("%0t: unexpected result beat, actual w=%0d", $time, rsp_w_part);
               fail_count++;
            end else begin
               e = quat_queue.pop_front();
               compare_part("w_part", e.w, rsp_w_part);
               compare_part("x_part", e.x, rsp_x_part);
               compare_part("y_part", e.y, rsp_y_part);
               compare_part("z_part", e.z, rsp_z_part);
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: test/tb_euler_to_quaternion.sv
// Testbench top for euler_to_quaternion: drives angle beats with random gaps
// and result stalls, and gives the verdict. Depends on e2q_pkg, the block
// and e2q_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_to_quaternion
   import e2q_pkg::*;
();

   localparam int STEPS       = CORDIC_STEPS_DEFAULT;
   localparam int WIDTH       = PART_WIDTH_DEFAULT;
   localparam int RANDOM_BEATS = 630;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [ANGLE_WIDTH-1:0] req_angle_x = '0;
   logic signed [ANGLE_WIDTH-1:0] req_angle_y = '0;
   logic signed [ANGLE_WIDTH-1:0] req_angle_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [WIDTH-1:0] rsp_w_part, rsp_x_part, rsp_y_part, rsp_z_part;
   int fail_count, pending_count;

   // Two-phase clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   euler_to_quaternion #(.CORDIC_STEPS(STEPS), .PART_WIDTH(WIDTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y), .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_w_part(rsp_w_part), .rsp_x_part(rsp_x_part),
      .rsp_y_part(rsp_y_part), .rsp_z_part(rsp_z_part)
   );

   e2q_checker #(.CORDIC_STEPS(STEPS), .PART_WIDTH(WIDTH)) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y), .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_w_part(rsp_w_part), .rsp_x_part(rsp_x_part),
      .rsp_y_part(rsp_y_part), .rsp_z_part(rsp_z_part),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Draw a random gap length; a third of the time it is zero outright.
   function automatic int draw_gap();
      return ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 0);
   endfunction

   // Drop valid for a random gap, then present one angle beat and hold it
   // until accepted. Valid stays high afterwards; the next call drops it only for a nonzero gap.
   task automatic send_angles(input logic signed [15:0] ax, ay, az);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      do @(posedge clock); while (!req_ready);
   endtask

   // Pick an angle: half within one turn, some full-range, some near the fold, a few near zero.
   function automatic logic signed [15:0] draw_angle();
      int pick;
      pick = $urandom_range(9, 0);
      if (pick < 5) return 16'($urandom_range(25736, 0) - 12868);
      if (pick < 7) return 16'($urandom);
      if (pick < 9) return 16'(($urandom_range(1, 0) ? 12868 : -12868)
                               + int'($urandom_range(8, 0)) - 4);
      return 16'(int'($urandom_range(6, 0)) - 3);
   endfunction

   // Result side: stall for a random count before each result, sometimes not at all.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus and verdict.
   initial begin
      logic signed [15:0] edges[10];
      int drain;
      edges = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868, 16'sd12869};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, zero, plus/minus one, plus/minus pi/2, the fold boundaries near plus/minus pi.
      for (int i = 0; i < 10; i++) send_angles(edges[i], edges[9 - i], edges[(i + 3) % 10]);
      send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
      send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
      send_angles(-16'sd12869, 16'sd12867, -16'sd12867);
      for (int n = 0; n < RANDOM_BEATS; n++)
         send_angles(draw_angle(), draw_angle(), draw_angle());
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      drain = STEPS + 8;
      repeat (drain) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Overall limit, far beyond the slowest correct run.
   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
